FILE: rtl/animation_frame_sequencer_defines.svh
// Assertion macros used by the sequencer top level.
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define AFS_CHECK_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// Next-cycle implication, quiet while reset is asserted.
`define AFS_CHECK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`endif

FILE: rtl/afs_pkg.sv
package afs_pkg;

	// Duration table geometry
	localparam int MAX_FRAMES = 256;
	localparam int DUR_AW     = $clog2(MAX_FRAMES);
	localparam int DUR_W      = 12;
	localparam int ACC_W      = 20;

	// Effective frame count saturates to the lower of 256 and the table depth
	localparam logic [8:0] CNT_CAP = 9'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

	localparam logic [DUR_W-1:0] DUR_MIN = 12'd10;
	localparam logic [DUR_W-1:0] DUR_MAX = 12'd2550;

	// Request codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_TOGGLE  = 3'd1;
	localparam logic [2:0] REQ_RESTART = 3'd2;
	localparam logic [2:0] REQ_HOLD    = 3'd3;
	localparam logic [2:0] REQ_RELEASE = 3'd4;
	localparam logic [2:0] REQ_SEEK    = 3'd5;
	localparam logic [2:0] REQ_SET_DUR = 3'd6;

	// Configuration register indexes
	localparam logic [2:0] CFG_FRAME_COUNT = 3'd0;
	localparam logic [2:0] CFG_LOOP_START  = 3'd1;
	localparam logic [2:0] CFG_LOOP_END_EN = 3'd2;
	localparam logic [2:0] CFG_LOOP_END    = 3'd3;
	localparam logic [2:0] CFG_LOOP_EN     = 3'd4;
	localparam logic [2:0] CFG_SPEED       = 3'd5;

	typedef struct packed {
		logic [8:0]  frame_count;
		logic [7:0]  loop_start;
		logic        loop_end_enable;
		logic [7:0]  loop_end;
		logic        loop_enable;
		logic [10:0] speed_q8;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [DUR_AW-1:0] addr;
		logic [DUR_W-1:0]  data;
	} dur_wr_t;

	typedef struct packed {
		logic [7:0] current_frame;
		logic       playing;
		logic       hold_active;
		logic       frame_changed;
	} result_t;

endpackage

FILE: rtl/afs_dur_mem.sv
module afs_dur_mem (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [afs_pkg::DUR_AW-1:0]    rd_addr,
	output logic [afs_pkg::DUR_W-1:0]     rd_data,
	input  afs_pkg::dur_wr_t              wr
);
	import afs_pkg::*;

	logic [DUR_W-1:0] mem_q [MAX_FRAMES];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/afs_core.sv
module afs_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       exec,
	input  logic [2:0]                 req,
	input  logic [7:0]                 fidx,
	input  logic [11:0]                dms,
	input  logic [afs_pkg::DUR_W-1:0]  rd_dur,
	input  afs_pkg::cfg_t              cfg,
	output logic [7:0]                 cur_index,
	output logic                       play_state,
	output logic                       hold_state,
	output afs_pkg::result_t           res,
	output afs_pkg::dur_wr_t           wr
);
	import afs_pkg::*;

	logic [7:0]       cur_q;
	logic             play_q;
	logic             hold_q;
	logic             eng_q;
	logic [ACC_W-1:0] acc_q;

	logic [7:0]       cur_n;
	logic             play_n;
	logic             hold_n;
	logic             eng_n;
	logic [ACC_W-1:0] acc_n;

	logic [8:0]       n;
	logic [7:0]       last;
	logic [7:0]       ls;
	logic [7:0]       le;
	logic [7:0]       lsle;
	logic             hold0;
	logic [ACC_W:0]   acc_sum;
	logic [ACC_W-1:0] acc_sat;
	logic [8:0]       cur_inc;
	logic [ACC_W-1:0] target;
	logic [DUR_W-1:0] dms_sat;

	// Derive effective frame count and loop markers
	always_comb begin
		if (cfg.frame_count == 9'd0) begin
			n = 9'd1;
		end else if (cfg.frame_count > CNT_CAP) begin
			n = CNT_CAP;
		end else begin
			n = cfg.frame_count;
		end
		last = 8'(n - 9'd1);
		ls   = (cfg.loop_start > last) ? last : cfg.loop_start;
		le   = (cfg.loop_end > last) ? last : cfg.loop_end;
		lsle = (ls < le) ? ls : le;
	end

	// Accumulate with saturation
	assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(cfg.speed_q8);
	assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
	assign cur_inc = {1'b0, cur_q} + 9'd1;
	assign target  = {rd_dur, 8'h00};
	assign hold0   = cfg.loop_end_enable ? hold_q : 1'b0;

	// Work out the next playback state for the request
	always_comb begin
		cur_n  = cur_q;
		play_n = play_q;
		hold_n = hold0;
		eng_n  = eng_q;
		acc_n  = acc_q;
		case (req)
			REQ_TICK: begin
				if (play_q || hold0) begin
					acc_n = acc_sat;
					if (n >= 9'd2 && acc_sat >= target) begin
						acc_n = '0;
						if (play_q) begin
							if (cur_inc >= n) begin
								if (cfg.loop_enable) begin
									cur_n = ls;
								end else begin
									cur_n  = last;
									play_n = 1'b0;
								end
							end else begin
								cur_n = cur_inc[7:0];
							end
						end else if (cur_q == le && eng_q) begin
							cur_n = lsle;
						end else if (cur_q >= last) begin
							hold_n = 1'b0;
						end else begin
							cur_n = cur_inc[7:0];
						end
					end
				end
			end
			REQ_TOGGLE: begin
				play_n = !play_q;
				if (!play_q) begin
					hold_n = 1'b0;
					acc_n  = '0;
					if (cur_q >= last) begin
						cur_n = 8'd0;
					end
				end
			end
			REQ_RESTART: begin
				cur_n  = 8'd0;
				play_n = 1'b1;
				hold_n = 1'b0;
				acc_n  = '0;
			end
			REQ_HOLD: begin
				if (cfg.loop_end_enable) begin
					play_n = 1'b0;
					eng_n  = 1'b1;
					if (!hold0) begin
						hold_n = 1'b1;
						cur_n  = 8'd0;
						acc_n  = '0;
					end else if (cur_q > le) begin
						cur_n = lsle;
					end
				end
			end
			REQ_RELEASE: begin
				if (cfg.loop_end_enable) begin
					eng_n = 1'b0;
					if (cur_q >= ls && cur_q <= le && ({1'b0, le} + 9'd1) < n) begin
						cur_n = le + 8'd1;
						acc_n = '0;
					end
				end
			end
			REQ_SEEK: begin
				cur_n = (fidx > last) ? last : fidx;
			end
			default: begin
			end
		endcase
	end

	// Saturate and issue duration writes
	always_comb begin
		if (dms < DUR_MIN) begin
			dms_sat = DUR_MIN;
		end else if (dms > DUR_MAX) begin
			dms_sat = DUR_MAX;
		end else begin
			dms_sat = dms;
		end
		wr.en   = exec && (req == REQ_SET_DUR) && (32'(fidx) < MAX_FRAMES);
		wr.addr = DUR_AW'(fidx);
		wr.data = dms_sat;
	end

	// Advance state on each executed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			play_q <= 1'b0;
			hold_q <= 1'b0;
			eng_q  <= 1'b0;
			acc_q  <= '0;
		end else if (exec) begin
			cur_q  <= cur_n;
			play_q <= play_n;
			hold_q <= hold_n;
			eng_q  <= eng_n;
			acc_q  <= acc_n;
		end
	end

	assign cur_index         = cur_q;
	assign play_state        = play_q;
	assign hold_state        = hold_q;
	assign res.current_frame = cur_n;
	assign res.playing       = play_n;
	assign res.hold_active   = hold_n;
	assign res.frame_changed = (cur_n != cur_q);

endmodule

FILE: rtl/animation_frame_sequencer.sv
// Animation frame sequencer.
// Input channel (in_valid/in_ready) carries one request per transaction: tick,
// play toggle, restart, hold press/release, seek or duration write. Every
// request yields exactly one result on the output channel (out_valid/out_ready)
// with the frame shown, the play and hold flags and a frame-changed mark.
// Configuration writes use cfg_valid/cfg_ready with a register index and data;
// cfg_ready is always high, and writes are expected only while idle.
// An accepted request moves the block from idle to its update state. The
// accept edge reads the current frame's duration from the synchronous table;
// the update edge, taken once the output register is free, updates the state
// and loads the output. No new request is taken until that update is done.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the following request holds in its update
// cycle until the output register frees up.
// Reset clears the playback state, the output valid and the configuration to
// its defaults; the duration table has no reset and must be written before use.
module animation_frame_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  frame_index,
	input  logic [11:0] duration_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  current_frame,
	output logic        playing,
	output logic        hold_active,
	output logic        frame_changed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import afs_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic              state_q;
	logic              out_valid_q;
	result_t           out_q;
	cfg_t              cfg_q;
	logic [2:0]        req_s1;
	logic [7:0]        fidx_s1;
	logic [11:0]       dms_s1;
	logic              accept;
	logic              exec;
	logic [7:0]        cur_index;
	logic              play_state;
	logic              hold_state;
	logic [DUR_W-1:0]  rd_dur;
	result_t           res;
	dur_wr_t           wr;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign exec      = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count     <= 9'd1;
			cfg_q.loop_start      <= 8'd0;
			cfg_q.loop_end_enable <= 1'b0;
			cfg_q.loop_end        <= 8'd0;
			cfg_q.loop_enable     <= 1'b1;
			cfg_q.speed_q8        <= 11'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_COUNT: cfg_q.frame_count     <= cfg_data[8:0];
				CFG_LOOP_START:  cfg_q.loop_start      <= cfg_data[7:0];
				CFG_LOOP_END_EN: cfg_q.loop_end_enable <= cfg_data[0];
				CFG_LOOP_END:    cfg_q.loop_end        <= cfg_data[7:0];
				CFG_LOOP_EN:     cfg_q.loop_enable     <= cfg_data[0];
				CFG_SPEED:       cfg_q.speed_q8        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequence: accept, then update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= ST_EXEC;
		end else if (exec) begin
			state_q <= ST_IDLE;
		end
	end

	// Capture the request with the table read
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			fidx_s1 <= frame_index;
			dms_s1  <= duration_ms;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_q <= res;
		end
	end

	afs_dur_mem u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (DUR_AW'(cur_index)),
		.rd_data (rd_dur),
		.wr      (wr)
	);

	afs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.exec       (exec),
		.req        (req_s1),
		.fidx       (fidx_s1),
		.dms        (dms_s1),
		.rd_dur     (rd_dur),
		.cfg        (cfg_q),
		.cur_index  (cur_index),
		.play_state (play_state),
		.hold_state (hold_state),
		.res        (res),
		.wr         (wr)
	);

	assign out_valid     = out_valid_q;
	assign current_frame = out_q.current_frame;
	assign playing       = out_q.playing;
	assign hold_active   = out_q.hold_active;
	assign frame_changed = out_q.frame_changed;

`include "animation_frame_sequencer_defines.svh"

	// Normal play and hold mode never run together
	`AFS_CHECK_NOW(a_flags_exclusive, clk, arst_n, play_state, !hold_state)
	// A request in its update cycle blocks new ones
	`AFS_CHECK_NOW(a_busy_blocks, clk, arst_n, state_q == ST_EXEC, !in_ready)
	// An executed request leaves a result waiting
	`AFS_CHECK_NEXT(a_exec_result, clk, arst_n, exec, out_valid && in_ready)
	// A duration write only happens in an update cycle
	`AFS_CHECK_NOW(a_write_in_exec, clk, arst_n, wr.en, exec && req_s1 == REQ_SET_DUR)

endmodule

FILE: bench/tb_animation_frame_sequencer.sv
`timescale 1ns / 100ps

module tb_animation_frame_sequencer;
	import afs_pkg::*;

	// Codes the package leaves out: the unused request and the unused register slot
	localparam logic [2:0] REQ_UNKNOWN = 3'd7;
	localparam logic [2:0] CFG_UNUSED  = 3'd7;

	localparam int          STALL_CYCLES  = 60;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          FILL_FRAMES   = 16;
	localparam int unsigned ACC_LIMIT     = (1 << ACC_W) - 1;

	// Predicts the frame shown after each request and holds the results still owed
	class playback_tracker;
		logic [DUR_W-1:0] durations [MAX_FRAMES];
		int unsigned frame, accum;
		bit play_on, hold_on, engaged;
		int unsigned count_reg, start_reg, end_reg, speed_reg;
		bit end_marker, wrap;
		result_t pending [$];
		int mismatches, requests, results, changes;

		function new();
			frame = 0;
			accum = 0;
			play_on = 0;
			hold_on = 0;
			engaged = 0;
			count_reg = 1;
			start_reg = 0;
			end_marker = 0;
			end_reg = 0;
			wrap = 1;
			speed_reg = 256;
			mismatches = 0;
			requests = 0;
			results = 0;
			changes = 0;
		endfunction

		function void note_config(logic [2:0] idx, logic [10:0] data);
			case (idx)
				CFG_FRAME_COUNT: count_reg = data[8:0];
				CFG_LOOP_START:  start_reg = data[7:0];
				CFG_LOOP_END_EN: end_marker = data[0];
				CFG_LOOP_END:    end_reg = data[7:0];
				CFG_LOOP_EN:     wrap = data[0];
				CFG_SPEED:       speed_reg = data;
				default: ;
			endcase
		endfunction

		// Frame count as the block uses it: zero counts as one, capped at the table
		function int unsigned frame_span();
			int unsigned n;
			n = (count_reg == 0) ? 1 : count_reg;
			if (n > CNT_CAP)
				n = CNT_CAP;
			return n;
		endfunction

		// Accumulate one millisecond and step the frame once its duration is reached
		function void advance_on_tick(int unsigned n);
			int unsigned last, ls, le;
			last = n - 1;
			ls = (start_reg < last) ? start_reg : last;
			le = (end_reg < last) ? end_reg : last;
			if (!play_on && !hold_on)
				return;
			accum += speed_reg;
			if (accum > ACC_LIMIT)
				accum = ACC_LIMIT;
			if (n < 2)
				return;
			if (accum < {durations[frame], 8'h00})
				return;
			accum = 0;
			if (play_on) begin
				frame++;
				if (frame >= n) begin
					if (wrap)
						frame = ls;
					else begin
						frame = last;
						play_on = 0;
					end
				end
			end else if (frame == le && engaged)
				frame = (ls < le) ? ls : le;
			else if (frame >= last)
				hold_on = 0;
			else
				frame++;
		endfunction

		function void note_request(logic [2:0] req, logic [7:0] idx, logic [11:0] dms);
			int unsigned n, last, ls, le, prev;
			result_t want;
			n = frame_span();
			last = n - 1;
			ls = (start_reg < last) ? start_reg : last;
			le = (end_reg < last) ? end_reg : last;
			prev = frame;
			if (!end_marker)
				hold_on = 0;
			case (req)
				REQ_TICK: advance_on_tick(n);
				REQ_TOGGLE: begin
					play_on = !play_on;
					if (play_on) begin
						hold_on = 0;
						accum = 0;
						if (frame >= last)
							frame = 0;
					end
				end
				REQ_RESTART: begin
					frame = 0;
					play_on = 1;
					hold_on = 0;
					accum = 0;
				end
				REQ_HOLD: begin
					if (end_marker) begin
						play_on = 0;
						engaged = 1;
						if (!hold_on) begin
							hold_on = 1;
							frame = 0;
							accum = 0;
						end else if (frame > le)
							frame = (ls < le) ? ls : le;
					end
				end
				REQ_RELEASE: begin
					// snap to the outro even when hold is not running
					if (end_marker) begin
						engaged = 0;
						if (frame >= ls && frame <= le && le + 1 < n) begin
							frame = le + 1;
							accum = 0;
						end
					end
				end
				REQ_SEEK: frame = (idx < last) ? idx : last;
				REQ_SET_DUR: begin
					if (dms < DUR_MIN)
						durations[idx] = DUR_MIN;
					else if (dms > DUR_MAX)
						durations[idx] = DUR_MAX;
					else
						durations[idx] = dms;
				end
				default: ;
			endcase
			want.current_frame = 8'(frame);
			want.playing = play_on;
			want.hold_active = hold_on;
			want.frame_changed = (frame != prev);
			pending = {pending, want};
			requests++;
		endfunction

		task flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
			$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, results);
			mismatches++;
		endtask

		task check_frame(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				flag_mismatch("result with nothing pending", got.current_frame, 8'd0);
				return;
			end
			want = pending.pop_front();
			results++;
			if (got.current_frame !== want.current_frame)
				flag_mismatch("current_frame", got.current_frame, want.current_frame);
			if (got.playing !== want.playing)
				flag_mismatch("playing", 8'(got.playing), 8'(want.playing));
			if (got.hold_active !== want.hold_active)
				flag_mismatch("hold_active", 8'(got.hold_active), 8'(want.hold_active));
			if (got.frame_changed !== want.frame_changed)
				flag_mismatch("frame_changed", 8'(got.frame_changed),
					8'(want.frame_changed));
			if (want.frame_changed)
				changes++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  req_type = REQ_TICK;
	logic [7:0]  frame_index = 8'd0;
	logic [11:0] duration_ms = 12'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  current_frame;
	logic        playing;
	logic        hold_active;
	logic        frame_changed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_FRAME_COUNT;
	logic [10:0] cfg_data = 11'd0;

	playback_tracker board = new();
	bit no_gaps = 1'b0;
	bit hold_off_armed = 1'b0;
	int settings = 0;

	animation_frame_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.frame_index   (frame_index),
		.duration_ms   (duration_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.current_frame (current_frame),
		.playing       (playing),
		.hold_active   (hold_active),
		.frame_changed (frame_changed),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bound the run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic bit gap_roll();
		return !no_gaps && ($urandom_range(99) < 17);
	endfunction

	// Take results; hold off for a long stretch when armed
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_frame({current_frame, playing, hold_active, frame_changed});
			if (hold_off_armed) begin
				hold_off_armed = 1'b0;
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= !gap_roll();
		end
	end

	// Offer one request and hold it until the transaction completes
	task automatic send_request(input logic [2:0] req, input logic [7:0] idx,
			input logic [11:0] dms);
		while (gap_roll()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		frame_index <= idx;
		duration_ms <= dms;
		do @(posedge clk); while (!in_ready);
		board.note_request(req, idx, dms);
	endtask

	task automatic send_ticks(input int k);
		repeat (k) send_request(REQ_TICK, 8'($urandom), 12'($urandom));
	endtask

	// Drop the input and wait for every owed result, then let the pipeline settle
	task automatic wait_results();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.note_config(idx, data);
	endtask

	task automatic apply_setting(input logic [10:0] cnt, input logic [10:0] ls,
			input logic [10:0] lee, input logic [10:0] le, input logic [10:0] len,
			input logic [10:0] spd);
		wait_results();
		write_reg(CFG_FRAME_COUNT, cnt);
		write_reg(CFG_LOOP_START, ls);
		write_reg(CFG_LOOP_END_EN, lee);
		write_reg(CFG_LOOP_END, le);
		write_reg(CFG_LOOP_EN, len);
		write_reg(CFG_SPEED, spd);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// One short, mostly well-formed burst of requests
	task automatic play_sequence();
		int pick;
		int unsigned span;
		logic [7:0] target;
		pick = $urandom_range(99);
		span = board.frame_span();
		if (pick < 30) begin
			// normal play from the top or from where it stands
			if ($urandom_range(1))
				send_request(REQ_RESTART, 8'($urandom), 12'($urandom));
			else if (!board.play_on)
				send_request(REQ_TOGGLE, 8'($urandom), 12'($urandom));
			send_ticks($urandom_range(4, 24));
			if ($urandom_range(3) == 0)
				send_request(REQ_TOGGLE, 8'($urandom), 12'($urandom));
		end else if (pick < 55) begin
			// hold through the loop region, then release into the outro
			send_request(REQ_HOLD, 8'($urandom), 12'($urandom));
			send_ticks($urandom_range(4, 30));
			if ($urandom_range(2) == 0) begin
				send_request(REQ_HOLD, 8'($urandom), 12'($urandom));
				send_ticks($urandom_range(1, 10));
			end
			send_request(REQ_RELEASE, 8'($urandom), 12'($urandom));
			send_ticks($urandom_range(3, 20));
		end else if (pick < 70) begin
			// seek mostly inside the animation, sometimes past its end
			target = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(span));
			send_request(REQ_SEEK, target, 12'($urandom));
			send_ticks($urandom_range(2, 10));
		end else if (pick < 80) begin
			// rewrite one duration, mostly short
			target = 8'($urandom_range(span - 1));
			send_request(REQ_SET_DUR, target,
				($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 30)));
			send_ticks($urandom_range(1, 6));
		end else begin
			// noise: any code, any fields
			repeat ($urandom_range(1, 3))
				send_request(3'($urandom), 8'($urandom),
					($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)));
		end
	endtask

	task automatic run_phase(input int budget, input bit steady, input bit squeeze);
		int first;
		bit paused;
		first = board.requests;
		paused = 1'b0;
		no_gaps = steady;
		if (squeeze)
			hold_off_armed = 1'b1;
		while (board.requests - first < budget) begin
			if (!paused && board.requests - first >= budget / 2) begin
				paused = 1'b1;
				wait_results();
			end
			play_sequence();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the durations of the first FILL_FRAMES frames with short frames
		for (int f = 0; f < FILL_FRAMES; f++)
			send_request(REQ_SET_DUR, 8'(f), 12'($urandom_range(0, 30)));

		// Single frame with reset configuration: unknown code, clamped seek, ignored hold
		send_request(REQ_UNKNOWN, 8'hFF, 12'hFFF);
		send_request(REQ_SEEK, 8'hFF, 12'h000);
		send_request(REQ_HOLD, 8'h00, 12'h000);
		send_request(REQ_RELEASE, 8'h00, 12'h000);
		send_request(REQ_TOGGLE, 8'h00, 12'h000);
		send_ticks(3);
		send_request(REQ_RESTART, 8'h00, 12'h000);
		send_request(REQ_TOGGLE, 8'h00, 12'h000);

		// Saturate duration writes at both ends, then restore a short frame
		send_request(REQ_SET_DUR, 8'hFF, 12'd0);
		send_request(REQ_SET_DUR, 8'hFF, 12'd9);
		send_request(REQ_SET_DUR, 8'hFF, 12'd10);
		send_request(REQ_SET_DUR, 8'hFF, 12'd2550);
		send_request(REQ_SET_DUR, 8'hFF, 12'd2551);
		send_request(REQ_SET_DUR, 8'hFF, 12'hFFF);
		send_request(REQ_SET_DUR, 8'hFF, 12'd12);

		// Hold corners: release without hold, press past the loop end
		apply_setting(11'd4, 11'd1, 11'd1, 11'd2, 11'd1, 11'd1024);
		write_reg(CFG_UNUSED, 11'h7FF);
		cfg_valid <= 1'b0;
		send_request(REQ_SEEK, 8'd1, 12'd0);
		send_request(REQ_RELEASE, 8'd0, 12'd0);
		send_request(REQ_HOLD, 8'd0, 12'd0);
		send_request(REQ_SEEK, 8'd3, 12'd0);
		send_request(REQ_HOLD, 8'd0, 12'd0);
		send_request(REQ_RELEASE, 8'd0, 12'd0);

		// Zero frame count plays one frame; ticks only grow the accumulator
		apply_setting(11'd0, 11'd0, 11'd0, 11'd0, 11'd1, 11'd2047);
		send_request(REQ_RESTART, 8'd0, 12'd0);
		send_ticks(6);

		// Oversized register values; the grown accumulator advances at once
		apply_setting(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'd13);
		send_ticks(2);
		send_request(REQ_SEEK, 8'hFF, 12'd0);
		send_request(REQ_HOLD, 8'd0, 12'd0);
		send_request(REQ_RELEASE, 8'd0, 12'd0);

		// Fixed settings: stop at the end, long output stall, full fill, odd speeds
		apply_setting(11'd2, 11'd0, 11'd0, 11'd0, 11'd0, 11'd1024);
		run_phase(40, 1'b1, 1'b0);
		apply_setting(11'd6, 11'd2, 11'd1, 11'd4, 11'd1, 11'd1024);
		run_phase(50, 1'b0, 1'b1);
		apply_setting(11'd16, 11'd10, 11'd1, 11'd13, 11'd1, 11'd2047);
		run_phase(30, 1'b0, 1'b0);
		apply_setting(11'd5, 11'd200, 11'd1, 11'd200, 11'd0, 11'd13);
		run_phase(20, 1'b0, 1'b0);
		apply_setting(11'd3, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0);
		run_phase(12, 1'b0, 1'b0);
		apply_setting(11'd1, 11'd0, 11'd1, 11'd0, 11'd1, 11'd256);
		run_phase(12, 1'b0, 1'b0);

		// Random small animations
		repeat (4) begin
			apply_setting(11'($urandom_range(2, 12)), 11'($urandom_range(0, 12)),
				11'($urandom_range(1)), 11'($urandom_range(0, 12)),
				11'($urandom_range(1)), 11'($urandom_range(13, 1024)));
			run_phase(25, 1'b0, 1'b0);
		end

		wait_results();
		$display("Covered %0d requests over %0d settings with %0d frame changes,", board.requests,
			settings, board.changes);
		$display("including hold loops, clamped registers and a long output stall.");
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
